// ----- rtl/tws_pkg.sv -----
// Shared types, constants and pipeline latencies for the tone waveform sample core.
`timescale 1ns / 1ps
package tws_pkg;

   // Input beat and result beat
   typedef struct packed {
      logic [31:0] phase_turns;
      logic [2:0]  waveform_select;
      logic [23:0] frequency_hz;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_value;
      logic [31:0]        phase_step;
   } rsp_type;

   typedef enum logic [2:0] {
      WAVE_SINE     = 3'd0,
      WAVE_SQUARE   = 3'd1,
      WAVE_SAW      = 3'd2,
      WAVE_TRIANGLE = 3'd3,
      WAVE_WHITE    = 3'd4,
      WAVE_PINK     = 3'd5
   } wave_type;

   localparam int unsigned RATE_W = 18;
   localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

   // Frequency clamp in Hz with 8 fraction bits (20 Hz and 20 kHz)
   localparam logic [22:0] FREQ_MIN = 23'd5120;
   localparam logic [22:0] FREQ_MAX = 23'd5120000;

   // Sine series in Q30
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [30:0] HALF_PI = 31'd1686629713;
   localparam int unsigned N_TERMS = 6;
   localparam logic [7:0] TERM_DIV [N_TERMS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
   // floor(2^32 / divisor)
   localparam logic [29:0] TERM_RECIP [N_TERMS] = '{30'd27531841, 30'd39045157,
      30'd59652323, 30'd102261126, 30'd214748364, 30'd715827882};
   localparam logic [15:0] SAMPLE_MAX = 16'd32767;

   // Gain 0.8 path: round(mag / (5 * 2^15))
   localparam logic [34:0] GAIN_BIAS  = 35'd81920;
   localparam logic [17:0] RECIP_FIVE = 18'd209715;  // floor(2^20 / 5)

   // Register stages of each unit
   localparam int unsigned SINE_LAT = 3 + 3 * N_TERMS + 2;
   localparam int unsigned WAVE_LAT = 3;
   localparam int unsigned DIV_STEPS = 12;
   localparam int unsigned DIV_LAT  = DIV_STEPS + 1;
   localparam int unsigned OUT_LAT  = SINE_LAT + 1;

endpackage

// ----- rtl/tws_sine.sv -----
// Pipelined quarter-wave Taylor series sine, one stage per multiply.
`timescale 1ns / 1ps
module tws_sine
   import tws_pkg::*;
(
   input  logic               clock,
   input  logic [31:0]        phase,
   output logic signed [15:0] sample
);

   // Fold phase into the first quadrant
   logic [1:0]  quad0_ff;
   logic [30:0] u_ff;
   always_ff @(posedge clock) begin
      quad0_ff <= phase[31:30];
      u_ff     <= phase[30] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
   end

   // Scale to radians
   logic [61:0] x_prod;
   logic [1:0]  quad1_ff;
   logic [30:0] x1_ff;
   assign x_prod = {31'd0, u_ff} * {31'd0, HALF_PI};
   always_ff @(posedge clock) begin
      quad1_ff <= quad0_ff;
      x1_ff    <= x_prod[60:30];
   end

   // Square of x
   logic [61:0] sq_prod;
   logic [30:0] xs_w  [N_TERMS+1];
   logic [31:0] x2s_w [N_TERMS+1];
   logic [30:0] ts_w  [N_TERMS+1];
   logic [1:0]  qs_w  [N_TERMS+1];
   logic [1:0]  quad2_ff;
   logic [30:0] x2x_ff;
   logic [31:0] x2_ff;
   assign sq_prod = {31'd0, x1_ff} * {31'd0, x1_ff};
   always_ff @(posedge clock) begin
      quad2_ff <= quad1_ff;
      x2x_ff   <= x1_ff;
      x2_ff    <= sq_prod[61:30];
   end
   assign xs_w[0]  = x2x_ff;
   assign x2s_w[0] = x2_ff;
   assign ts_w[0]  = Q30_ONE;
   assign qs_w[0]  = quad2_ff;

   // Horner steps: term = 1 - (x2 * term) / div, three stages each
   for (genvar i = 0; i < N_TERMS; i++) begin : g_term
      logic [62:0] pa_prod;
      logic [31:0] pa_ff, pb_ff;
      logic [30:0] xa_ff, xb_ff, xc_ff;
      logic [31:0] x2a_ff, x2b_ff, x2c_ff;
      logic [1:0]  qa_ff, qb_ff, qc_ff;
      logic [61:0] pb_prod;
      logic [29:0] q0_ff;
      logic [37:0] qd;
      logic [31:0] rem;
      logic [29:0] quo;
      logic [30:0] tc_ff;

      assign pa_prod = {31'd0, x2s_w[i]} * {32'd0, ts_w[i]};
      always_ff @(posedge clock) begin
         pa_ff  <= pa_prod[61:30];
         xa_ff  <= xs_w[i];
         x2a_ff <= x2s_w[i];
         qa_ff  <= qs_w[i];
      end

      // Estimate quotient by reciprocal, low by at most one
      assign pb_prod = {30'd0, pa_ff} * {32'd0, TERM_RECIP[i]};
      always_ff @(posedge clock) begin
         q0_ff  <= pb_prod[61:32];
         pb_ff  <= pa_ff;
         xb_ff  <= xa_ff;
         x2b_ff <= x2a_ff;
         qb_ff  <= qa_ff;
      end

      // Correct quotient and close the step
      assign qd  = {8'd0, q0_ff} * {30'd0, TERM_DIV[i]};
      assign rem = pb_ff - qd[31:0];
      assign quo = (rem >= {24'd0, TERM_DIV[i]}) ? (q0_ff + 30'd1) : q0_ff;
      always_ff @(posedge clock) begin
         tc_ff  <= Q30_ONE - {1'b0, quo};
         xc_ff  <= xb_ff;
         x2c_ff <= x2b_ff;
         qc_ff  <= qb_ff;
      end
      assign xs_w[i+1]  = xc_ff;
      assign x2s_w[i+1] = x2c_ff;
      assign ts_w[i+1]  = tc_ff;
      assign qs_w[i+1]  = qc_ff;
   end

   // Final product
   logic [61:0] s_prod;
   logic [31:0] s_ff;
   logic [1:0]  quads_ff;
   assign s_prod = {31'd0, xs_w[N_TERMS]} * {31'd0, ts_w[N_TERMS]};
   always_ff @(posedge clock) begin
      s_ff     <= s_prod[61:30];
      quads_ff <= qs_w[N_TERMS];
   end

   // Round half up, saturate, apply sign
   logic [31:0] s_round;
   logic [15:0] mag;
   logic signed [15:0] sample_ff;
   assign s_round = s_ff + 32'd16384;
   assign mag = (s_round[31:15] > {1'b0, SAMPLE_MAX}) ? SAMPLE_MAX : s_round[30:15];
   always_ff @(posedge clock) begin
      sample_ff <= quads_ff[1] ? -$signed(mag) : $signed(mag);
   end
   assign sample = sample_ff;

endmodule

// ----- rtl/tws_wave.sv -----
// Square, sawtooth and triangle samples with gain 0.8, three stages.
`timescale 1ns / 1ps
module tws_wave
   import tws_pkg::*;
(
   input  logic               clock,
   input  logic [31:0]        phase,
   input  logic [2:0]         select,
   output logic signed [15:0] sample
);

   // Build the unscaled shape in units of 2^-32
   logic signed [34:0] shape;
   logic [31:0]        tri_abs;
   logic [34:0]        mag;
   logic [34:0]        biased;
   always_comb begin
      tri_abs = phase[31] ? (phase - 32'h8000_0000) : (32'h8000_0000 - phase);
      unique case (select)
         WAVE_SQUARE:   shape = phase[31] ? -35'sh1_0000_0000 : 35'sh1_0000_0000;
         WAVE_SAW:      shape = $signed({2'b00, phase, 1'b0}) - 35'sh1_0000_0000;
         WAVE_TRIANGLE: shape = $signed({1'b0, tri_abs, 2'b00}) - 35'sh1_0000_0000;
         default:       shape = '0;
      endcase
      mag    = shape[34] ? $unsigned(-shape) : $unsigned(shape);
      biased = mag + GAIN_BIAS;
   end

   logic [17:0] y1_ff, y2_ff;
   logic        neg1_ff, neg2_ff;
   always_ff @(posedge clock) begin
      y1_ff   <= biased[32:15];
      neg1_ff <= shape[34];
   end

   // Divide by five through a reciprocal
   logic [35:0] prod;
   logic [15:0] q0_ff;
   assign prod = {18'd0, y1_ff} * {18'd0, RECIP_FIVE};
   always_ff @(posedge clock) begin
      q0_ff   <= prod[35:20];
      y2_ff   <= y1_ff;
      neg2_ff <= neg1_ff;
   end

   // Correct the estimate and apply sign
   logic [17:0] rem;
   logic [15:0] quo;
   logic signed [15:0] sample_ff;
   assign rem = y2_ff - ({2'b00, q0_ff} * 18'd5);
   assign quo = (rem >= 18'd5) ? (q0_ff + 16'd1) : q0_ff;
   always_ff @(posedge clock) begin
      sample_ff <= neg2_ff ? -$signed(quo) : $signed(quo);
   end
   assign sample = sample_ff;

endmodule

// ----- rtl/tws_div.sv -----
// Phase step divider: clamped frequency over sample rate, four quotient bits a stage.
`timescale 1ns / 1ps
module tws_div
   import tws_pkg::*;
(
   input  logic              clock,
   input  logic [23:0]       freq,
   input  logic [RATE_W-1:0] rate,
   output logic [31:0]       step
);

   // Clamp and form the rounded dividend
   logic [22:0] fclamp;
   always_comb begin
      priority if (freq < {1'b0, FREQ_MIN}) begin
         fclamp = FREQ_MIN;
      end else if (freq > {1'b0, FREQ_MAX}) begin
         fclamp = FREQ_MAX;
      end else begin
         fclamp = freq[22:0];
      end
   end

   logic [47:0]       num_w  [DIV_STEPS+1];
   logic [RATE_W-1:0] rem_w  [DIV_STEPS+1];
   logic [31:0]       quo_w  [DIV_STEPS+1];
   logic [RATE_W-1:0] dv_w   [DIV_STEPS+1];
   logic              zero_w [DIV_STEPS+1];

   logic [47:0]       num0_ff;
   logic [RATE_W-1:0] dv0_ff;
   logic              zero0_ff;
   always_ff @(posedge clock) begin
      num0_ff  <= {1'b0, fclamp, 24'd0} + {31'd0, rate[RATE_W-1:1]};
      dv0_ff   <= rate;
      zero0_ff <= (rate == '0);
   end
   assign num_w[0]  = num0_ff;
   assign rem_w[0]  = '0;
   assign quo_w[0]  = '0;
   assign dv_w[0]   = dv0_ff;
   assign zero_w[0] = zero0_ff;

   // Restoring division, four bits per stage
   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      logic [47:0]       num_c;
      logic [RATE_W-1:0] rem_c;
      logic [31:0]       quo_c;
      logic [RATE_W:0]   trial;
      logic [47:0]       num_ff;
      logic [RATE_W-1:0] rem_ff;
      logic [31:0]       quo_ff;
      logic [RATE_W-1:0] dv_ff;
      logic              zero_ff;
      always_comb begin
         num_c = num_w[s];
         rem_c = rem_w[s];
         quo_c = quo_w[s];
         trial = '0;
         for (int b = 0; b < 4; b++) begin
            trial = {rem_c, num_c[47]};
            num_c = {num_c[46:0], 1'b0};
            if (trial >= {1'b0, dv_w[s]}) begin
               rem_c = RATE_W'(trial - {1'b0, dv_w[s]});
               quo_c = {quo_c[30:0], 1'b1};
            end else begin
               rem_c = trial[RATE_W-1:0];
               quo_c = {quo_c[30:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         num_ff  <= num_c;
         rem_ff  <= rem_c;
         quo_ff  <= quo_c;
         dv_ff   <= dv_w[s];
         zero_ff <= zero_w[s];
      end
      assign num_w[s+1]  = num_ff;
      assign rem_w[s+1]  = rem_ff;
      assign quo_w[s+1]  = quo_ff;
      assign dv_w[s+1]   = dv_ff;
      assign zero_w[s+1] = zero_ff;
   end

   // Zero rate forces a zero step
   assign step = zero_w[DIV_STEPS] ? 32'd0 : quo_w[DIV_STEPS];

endmodule

// ----- rtl/tone_waveform_sample_core.sv -----
// Top level of the tone waveform sample core: handshake, alignment and result mux.
`timescale 1ns / 1ps
// Usage
//   Input: drive req_data and pulse req_start; a beat is taken on a clock edge
//   where req_start is high and busy is low. busy is high only right after
//   reset, so one beat can be taken every cycle.
//   Output: each beat yields one result on rsp_data, shown for one cycle with
//   rsp_valid high. The receiver cannot stall; results must be taken as shown.
//   Config: csr_data carries sample_rate_hz and is written when csr_valid is
//   high (csr_ready is always high). Write it only while no beat is in flight.
// Pipeline and throughput
//   Throughput is one beat per cycle while busy is low. The result beat is
//   registered after the last sine stage, so the pipe depth is set by the sine
//   series: six Horner steps of three stages each (product, reciprocal
//   estimate, correction) plus scaling and rounding stages. The step divider
//   (13 stages) and the gain path (3 stages) are delayed to match.
// Reset
//   Synchronous reset clears the valid line, drops in-flight beats, raises
//   busy for one cycle and loads sample_rate_hz with 48000.
module tone_waveform_sample_core
   import tws_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [RATE_W-1:0] csr_data
);

   logic accept;
   logic busy_ff;
   logic [RATE_W-1:0] rate_ff;

   // Hold busy for one cycle out of reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end
   assign busy   = busy_ff;
   assign accept = req_start & ~busy_ff;

   // Sample rate register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else if (csr_valid) begin
         rate_ff <= csr_data;
      end
   end

   // Datapath units
   logic signed [15:0] sine_sample, wave_sample;
   logic [31:0]        div_step;

   tws_sine u_sine (
      .clock  (clock),
      .phase  (req_data.phase_turns),
      .sample (sine_sample)
   );

   tws_wave u_wave (
      .clock  (clock),
      .phase  (req_data.phase_turns),
      .select (req_data.waveform_select),
      .sample (wave_sample)
   );

   tws_div u_div (
      .clock (clock),
      .freq  (req_data.frequency_hz),
      .rate  (rate_ff),
      .step  (div_step)
   );

   // Advance valid bits, the waveform code and the gain and step results alongside the sine pipe
   logic              valid_ff [SINE_LAT];
   logic [2:0]        sel_ff   [SINE_LAT];
   logic signed [15:0] wave_dly_ff [SINE_LAT-WAVE_LAT];
   logic [31:0]       step_dly_ff [SINE_LAT-DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SINE_LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= accept;
         for (int i = 1; i < SINE_LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      sel_ff[0] <= req_data.waveform_select;
      for (int i = 1; i < SINE_LAT; i++) begin
         sel_ff[i] <= sel_ff[i-1];
      end
      wave_dly_ff[0] <= wave_sample;
      for (int i = 1; i < SINE_LAT - WAVE_LAT; i++) begin
         wave_dly_ff[i] <= wave_dly_ff[i-1];
      end
      step_dly_ff[0] <= div_step;
      for (int i = 1; i < SINE_LAT - DIV_LAT; i++) begin
         step_dly_ff[i] <= step_dly_ff[i-1];
      end
   end

   // Pick the sample and register the result beat
   logic signed [15:0] sample_sel;
   always_comb begin
      unique case (sel_ff[SINE_LAT-1])
         WAVE_SINE:     sample_sel = sine_sample;
         WAVE_SQUARE,
         WAVE_SAW,
         WAVE_TRIANGLE: sample_sel = wave_dly_ff[SINE_LAT-WAVE_LAT-1];
         default:       sample_sel = '0;
      endcase
   end

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic [2:0] rsp_sel_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff[SINE_LAT-1];
      end
      rsp_data_ff.sample_value <= sample_sel;
      rsp_data_ff.phase_step   <= step_dly_ff[SINE_LAT-DIV_LAT-1];
      rsp_sel_ff               <= sel_ff[SINE_LAT-1];
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Every result beat traces back to an accepted beat
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, OUT_LAT))
      else $error("result beat without a matching input beat");

   // Noise and unused codes give a zero sample
   a_noise_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sel_ff[2] == 1'b1) |-> rsp_data.sample_value == 16'sd0)
      else $error("noise code produced a nonzero sample");

   // Square sits at plus or minus 0.8
   a_square_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sel_ff == WAVE_SQUARE) |->
         (rsp_data.sample_value == 16'sd26214 || rsp_data.sample_value == -16'sd26214))
      else $error("square level off");

endmodule
